>>> design/bclru_pkg.sv
// Shared types and constants for the block cache directory.
// Operation and status codes, controller states, command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package bclru_pkg;

  localparam int NUM_ENTRIES_DEF = 16;
  localparam int STAMP_BITS_DEF  = 32;

  localparam int KIND_W    = 3;
  localparam int ARK_W     = 8;
  localparam int BLK_W     = 24;
  localparam int TAG_W     = ARK_W + BLK_W;
  localparam int STATUS_W  = 2;
  localparam int OUT_IDX_W = 4;
  localparam int S_DATA_W  = 40;
  localparam int M_DATA_W  = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP      = 3'd0,
    KIND_START_READ  = 3'd1,
    KIND_READ_ISSUED = 3'd2,
    KIND_READ_DONE   = 3'd3,
    KIND_WRITE_OFFER = 3'd4,
    KIND_WRITE_DONE  = 3'd5,
    KIND_SPINUP      = 3'd6
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_BUSY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_TAGRD,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic scan_step;
    logic tag_read;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } stat_t;

endpackage

>>> design/bclru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while rd_en is low. No dependencies.
`timescale 1ns / 1ps

module bclru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/bclru_ctrl.sv
// Controller state machine for the block cache directory.
// Sequences accept, entry scan, tag read and commit. Uses bclru_pkg.
`timescale 1ns / 1ps

module bclru_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output bclru_pkg::cmd_t   cmd,
  input  bclru_pkg::stat_t  stat
);

  bclru_pkg::state_t state;
  bclru_pkg::state_t state_next;
  logic              m_tvalid_next;
  logic              out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bclru_pkg::S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bclru_pkg::S_IDLE:  if (s_tvalid) state_next = bclru_pkg::S_SCAN;
      bclru_pkg::S_SCAN:  if (stat.scan_last) state_next = bclru_pkg::S_DRAIN;
      bclru_pkg::S_DRAIN: state_next = bclru_pkg::S_TAGRD;
      bclru_pkg::S_TAGRD: state_next = bclru_pkg::S_APPLY;
      bclru_pkg::S_APPLY: if (out_free) state_next = bclru_pkg::S_IDLE;
      default:            state_next = bclru_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    cmd           = '0;
    unique case (state)
      bclru_pkg::S_IDLE: begin
        s_tready     = 1'b1;
        cmd.latch_in = s_tvalid;
      end
      bclru_pkg::S_SCAN:  cmd.scan_step = 1'b1;
      bclru_pkg::S_DRAIN: cmd = '0;
      bclru_pkg::S_TAGRD: cmd.tag_read = 1'b1;
      bclru_pkg::S_APPLY: cmd.apply = out_free;
      default:            cmd = '0;
    endcase
    if (cmd.apply) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  // no second word taken before the first is committed
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("word accepted while another is in progress");

  // a commit always shows up as a pending result
  a_apply_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> m_tvalid)
    else $error("commit did not raise m_tvalid");

  // datapath commands are mutually exclusive
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.latch_in, cmd.scan_step, cmd.tag_read, cmd.apply}))
    else $error("overlapping datapath commands");

endmodule

>>> design/bclru_dp.sv
// Datapath for the block cache directory: entry state, stamp counter,
// serial scan compare unit, commit logic and result register.
// Uses bclru_pkg and bclru_ram.
`timescale 1ns / 1ps

module bclru_dp #(
  parameter int NUM_ENTRIES = bclru_pkg::NUM_ENTRIES_DEF,
  parameter int STAMP_BITS  = bclru_pkg::STAMP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bclru_pkg::cmd_t                   cmd,
  output bclru_pkg::stat_t                  stat,
  input  logic [bclru_pkg::KIND_W-1:0]      in_kind,
  input  logic [bclru_pkg::ARK_W-1:0]       in_ark,
  input  logic [bclru_pkg::BLK_W-1:0]       in_blk,
  input  logic                              in_failed,
  input  logic                              in_accepted,
  output logic [bclru_pkg::STATUS_W-1:0]    out_status,
  output logic [bclru_pkg::OUT_IDX_W-1:0]   out_index,
  output logic [bclru_pkg::ARK_W-1:0]       out_ark,
  output logic [bclru_pkg::BLK_W-1:0]       out_blk
);

  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam int EXT_W = IDX_W + bclru_pkg::OUT_IDX_W;

  // latched item
  bclru_pkg::kind_t              kind_q;
  logic [bclru_pkg::ARK_W-1:0]   ark_q;
  logic [bclru_pkg::BLK_W-1:0]   blk_q;
  logic                          failed_q;
  logic                          accepted_q;

  // per-entry flags
  logic [NUM_ENTRIES-1:0] tag_valid;
  logic [NUM_ENTRIES-1:0] written;
  logic [NUM_ENTRIES-1:0] stamp_set;

  logic [STAMP_BITS-1:0] counter;
  logic [STAMP_BITS-1:0] counter_next;
  logic                  reading_active;
  logic [IDX_W-1:0]      reading_entry;
  logic                  writing_active;
  logic [IDX_W-1:0]      writing_entry;

  // scan unit
  logic [IDX_W-1:0]      scan_cnt;
  logic                  cmp_vld;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  found;
  logic [IDX_W-1:0]      found_idx;
  logic                  best_valid;
  logic [IDX_W-1:0]      best_idx;
  logic [STAMP_BITS-1:0] best_stamp;

  logic [bclru_pkg::TAG_W-1:0] tag_rd;
  logic [STAMP_BITS-1:0]       stamp_ram_rd;
  logic [STAMP_BITS-1:0]       stamp_rd;
  logic                        excl;
  logic                        take;
  logic                        match;

  // commit decisions
  bclru_pkg::status_t status_c;
  logic [IDX_W-1:0]   e_c;
  logic               show_c;
  logic               refresh_c;
  logic               claim_c;
  logic               mark_written_c;
  logic               ra_n;
  logic [IDX_W-1:0]   re_n;
  logic               wa_n;
  logic [IDX_W-1:0]   we_n;
  logic [EXT_W-1:0]   e_ext;

  assign stat.scan_last = (scan_cnt == IDX_W'(NUM_ENTRIES - 1));

  bclru_ram #(
    .WIDTH (bclru_pkg::TAG_W),
    .DEPTH (NUM_ENTRIES)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (cmd.apply && claim_c),
    .wr_addr (e_c),
    .wr_data ({blk_q, ark_q}),
    .rd_en   (cmd.scan_step || cmd.tag_read),
    .rd_addr (cmd.tag_read ? best_idx : scan_cnt),
    .rd_data (tag_rd)
  );

  bclru_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (NUM_ENTRIES)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (cmd.apply && refresh_c),
    .wr_addr (e_c),
    .wr_data (counter_next),
    .rd_en   (cmd.scan_step),
    .rd_addr (scan_cnt),
    .rd_data (stamp_ram_rd)
  );

  // an entry whose stamp was never written reads as its reset stamp
  always_comb begin
    stamp_rd = stamp_set[cmp_idx] ? stamp_ram_rd
                                  : STAMP_BITS'(cmp_idx) + STAMP_BITS'(1);
    excl = (writing_active && writing_entry == cmp_idx) ||
           (reading_active && reading_entry == cmp_idx) ||
           (kind_q == bclru_pkg::KIND_WRITE_OFFER && written[cmp_idx]);
    if (kind_q == bclru_pkg::KIND_SPINUP) begin
      take = stamp_rd > best_stamp;
    end else begin
      take = !excl && (stamp_rd < best_stamp);
    end
    match = tag_valid[cmp_idx] && (tag_rd == {blk_q, ark_q});
  end

  assign counter_next = (counter != '1) ? counter + STAMP_BITS'(1) : counter;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_q     <= bclru_pkg::kind_t'(in_kind);
      ark_q      <= in_ark;
      blk_q      <= in_blk;
      failed_q   <= in_failed;
      accepted_q <= in_accepted;
    end
  end

  // scan: one entry per cycle, compare in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt   <= '0;
      cmp_vld    <= 1'b0;
      cmp_idx    <= '0;
      found      <= 1'b0;
      found_idx  <= '0;
      best_valid <= 1'b0;
      best_idx   <= '0;
      best_stamp <= '0;
    end else begin
      cmp_vld <= cmd.scan_step;
      cmp_idx <= scan_cnt;
      if (cmd.latch_in) begin
        scan_cnt  <= '0;
        found     <= 1'b0;
        found_idx <= '0;
        best_idx  <= '0;
        if (in_kind == bclru_pkg::KIND_SPINUP) begin
          best_valid <= 1'b1;
          best_stamp <= '0;
        end else begin
          best_valid <= 1'b0;
          best_stamp <= counter;
        end
      end else begin
        if (cmd.scan_step) begin
          scan_cnt <= scan_cnt + IDX_W'(1);
        end
        if (cmp_vld) begin
          if (!found && match) begin
            found     <= 1'b1;
            found_idx <= cmp_idx;
          end
          if (take) begin
            best_valid <= 1'b1;
            best_idx   <= cmp_idx;
            best_stamp <= stamp_rd;
          end
        end
      end
    end
  end

  always_comb begin
    status_c       = bclru_pkg::ST_MISS;
    e_c            = '0;
    show_c         = 1'b0;
    refresh_c      = 1'b0;
    claim_c        = 1'b0;
    mark_written_c = 1'b0;
    ra_n           = reading_active;
    re_n           = reading_entry;
    wa_n           = writing_active;
    we_n           = writing_entry;
    case (kind_q)
      bclru_pkg::KIND_LOOKUP: begin
        if (found && !(reading_active && reading_entry == found_idx)) begin
          status_c  = bclru_pkg::ST_OK;
          e_c       = found_idx;
          refresh_c = 1'b1;
        end
      end
      bclru_pkg::KIND_START_READ: begin
        if (reading_active) begin
          status_c = bclru_pkg::ST_BUSY;
        end else if (best_valid) begin
          status_c = bclru_pkg::ST_OK;
          e_c      = best_idx;
          claim_c  = 1'b1;
          ra_n     = 1'b1;
          re_n     = best_idx;
        end
      end
      bclru_pkg::KIND_READ_ISSUED: begin
        if (reading_active) begin
          status_c = bclru_pkg::ST_OK;
          e_c      = reading_entry;
          if (failed_q) begin
            ra_n = 1'b0;
          end else begin
            refresh_c = 1'b1;
          end
        end
      end
      bclru_pkg::KIND_READ_DONE: begin
        if (reading_active) begin
          status_c  = bclru_pkg::ST_OK;
          e_c       = reading_entry;
          refresh_c = 1'b1;
          ra_n      = 1'b0;
        end
      end
      bclru_pkg::KIND_WRITE_OFFER: begin
        if (writing_active) begin
          status_c = bclru_pkg::ST_BUSY;
        end else if (best_valid) begin
          status_c       = bclru_pkg::ST_OK;
          e_c            = best_idx;
          show_c         = 1'b1;
          mark_written_c = 1'b1;
          if (accepted_q) begin
            wa_n = 1'b1;
            we_n = best_idx;
          end
        end
      end
      bclru_pkg::KIND_WRITE_DONE: begin
        if (writing_active) begin
          status_c = bclru_pkg::ST_OK;
          e_c      = writing_entry;
          wa_n     = 1'b0;
        end
      end
      bclru_pkg::KIND_SPINUP: begin
        if (reading_active) begin
          status_c = bclru_pkg::ST_BUSY;
        end else begin
          status_c = bclru_pkg::ST_OK;
          e_c      = best_idx;
          show_c   = 1'b1;
          ra_n     = 1'b1;
          re_n     = best_idx;
        end
      end
      default: status_c = bclru_pkg::ST_MISS;
    endcase
  end

  assign e_ext = EXT_W'(e_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid      <= '0;
      written        <= '1;
      stamp_set      <= '0;
      counter        <= STAMP_BITS'(NUM_ENTRIES);
      reading_active <= 1'b0;
      reading_entry  <= '0;
      writing_active <= 1'b0;
      writing_entry  <= '0;
    end else if (cmd.apply) begin
      reading_active <= ra_n;
      reading_entry  <= re_n;
      writing_active <= wa_n;
      writing_entry  <= we_n;
      if (refresh_c) begin
        counter        <= counter_next;
        stamp_set[e_c] <= 1'b1;
      end
      if (claim_c) begin
        tag_valid[e_c] <= 1'b1;
        written[e_c]   <= 1'b0;
      end
      if (mark_written_c) begin
        written[e_c] <= 1'b1;
      end
    end
  end

  // result register, loaded on commit
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_status <= status_c;
      if (status_c == bclru_pkg::ST_OK) begin
        out_index <= e_ext[bclru_pkg::OUT_IDX_W-1:0];
      end else begin
        out_index <= '0;
      end
      if (status_c == bclru_pkg::ST_OK && show_c && tag_valid[e_c]) begin
        out_ark <= tag_rd[bclru_pkg::ARK_W-1:0];
        out_blk <= tag_rd[bclru_pkg::TAG_W-1:bclru_pkg::ARK_W];
      end else begin
        out_ark <= '0;
        out_blk <= '0;
      end
    end
  end

  // stamp counter only moves forward
  a_counter_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> counter >= $past(counter))
    else $error("stamp counter went backwards");

  // a read never claims the entry being written
  a_claim_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && claim_c) |-> !(writing_active && writing_entry == e_c))
    else $error("read claimed the writing entry");

  // a lookup match always points at a valid entry
  a_found_valid: assert property (@(posedge clk) disable iff (rst)
    found |-> tag_valid[found_idx])
    else $error("match on an invalid entry");

endmodule

>>> design/block_cache_lru_timestamp.sv
// Top level of the fully associative block cache directory (timestamp LRU).
// Joins the controller and the datapath. Uses bclru_pkg, bclru_ctrl,
// bclru_dp (which holds two bclru_ram instances).
//
//  channel  | dir | tdata (lsb up)                             | tuser
//  ---------+-----+--------------------------------------------+-----------
//  s_*      | in  | ark_number, block_number, failed, accepted | kind
//  m_*      | out | entry_index, entry_ark, entry_block        | status
//
// The result register loads at commit, after these steps in order: the tag and
// stamp RAMs are read one entry per cycle through a single compare unit, then
// a drain step, a tag read for the chosen entry and the commit itself. The
// next word is taken only in the idle state, so no word is accepted before
// the previous one is committed. Reset is synchronous; per-entry flags stand
// for the reset tags and stamps, so no clearing pass is needed.
// A result waiting on m_tready does not block acceptance of the next word;
// that word stalls only at commit until the result register is free.
`timescale 1ns / 1ps

module block_cache_lru_timestamp #(
  parameter int NUM_ENTRIES = bclru_pkg::NUM_ENTRIES_DEF,
  parameter int STAMP_BITS  = bclru_pkg::STAMP_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [7:0] ark_number, [31:8] block_number, [32] failed, [33] accepted
  input  logic [bclru_pkg::S_DATA_W-1:0]     s_tdata,
  // [2:0] kind
  input  logic [bclru_pkg::KIND_W-1:0]       s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [3:0] entry_index, [11:4] entry_ark, [35:12] entry_block
  output logic [bclru_pkg::M_DATA_W-1:0]     m_tdata,
  // [1:0] status
  output logic [bclru_pkg::STATUS_W-1:0]     m_tuser
);

  localparam int OUT_USED = bclru_pkg::OUT_IDX_W + bclru_pkg::TAG_W;

  bclru_pkg::cmd_t  cmd;
  bclru_pkg::stat_t stat;

  logic [bclru_pkg::OUT_IDX_W-1:0] out_index;
  logic [bclru_pkg::ARK_W-1:0]     out_ark;
  logic [bclru_pkg::BLK_W-1:0]     out_blk;

  bclru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  bclru_dp #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .STAMP_BITS  (STAMP_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_kind     (s_tuser),
    .in_ark      (s_tdata[7:0]),
    .in_blk      (s_tdata[31:8]),
    .in_failed   (s_tdata[32]),
    .in_accepted (s_tdata[33]),
    .out_status  (m_tuser),
    .out_index   (out_index),
    .out_ark     (out_ark),
    .out_blk     (out_blk)
  );

  // pack the result word, pad bits held at zero
  assign m_tdata = {{(bclru_pkg::M_DATA_W - OUT_USED){1'b0}}, out_blk, out_ark, out_index};

endmodule
